FILE: src/sliding_window_min_max_assert.svh
// assertion macros used by the checker file
`ifndef SLIDING_WINDOW_MIN_MAX_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_ASSERT_SVH

// condition implies consequence in the same cycle
`define SWMM_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("sliding window min max: check failed");

// condition implies consequence in the next cycle
`define SWMM_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("sliding window min max: check failed");

`endif

FILE: src/swmm_pkg.sv
// shared types and constants for the sliding window min/max block
`timescale 1ns / 1ps

package swmm_pkg;

    localparam int WIN_LEN_W = 11;
    localparam int SAMPLE_W  = 32;
    localparam int IDX_W     = 32;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH
    } swmm_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic push;
    } swmm_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_busy;
        logic result_due;
        logic out_free;
    } swmm_status_t;

endpackage

FILE: src/swmm_deque.sv
// one monotonic deque: ring memory, head/tail pointers and occupancy count
`timescale 1ns / 1ps

module swmm_deque #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  swmm_pkg::swmm_cmd_t               cmd,
    input  logic                              find_min,
    input  logic                              last,
    input  logic [$clog2(WINDOW_MAX):0]       idx_low,
    input  logic [$clog2(WINDOW_MAX):0]       win,
    input  logic signed [swmm_pkg::SAMPLE_W-1:0] sample,
    output logic                              busy,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] front_val
);
    import swmm_pkg::*;

    localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int AW = $clog2(WINDOW_MAX) + 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int EW = AW + SAMPLE_W;
    localparam logic [PW-1:0] LAST_POS = PW'(WINDOW_MAX - 1);

    logic [EW-1:0] mem [WINDOW_MAX];

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [EW-1:0] head_ent_reg;
    logic [EW-1:0] tail_ent_reg;

    logic                       nonempty;
    logic [AW-1:0]              age;
    logic signed [SAMPLE_W-1:0] tail_val;
    logic                       stale;
    logic                       beaten;
    logic                       expire;
    logic                       pop;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        ring_next = (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
        ring_prev = (p == '0) ? LAST_POS : p - 1'b1;
    endfunction

    // head expiry and tail domination tests
    assign nonempty = (count_reg != '0);
    assign age      = idx_low - head_ent_reg[EW-1:SAMPLE_W];
    assign tail_val = $signed(tail_ent_reg[SAMPLE_W-1:0]);
    assign stale    = nonempty && (age >= win);
    assign beaten   = nonempty && (find_min ? (tail_val > sample) : (tail_val < sample));
    assign busy     = stale || beaten;
    assign expire   = cmd.scan && stale;
    // a single entry that is both stale and beaten is removed once
    assign pop      = cmd.scan && beaten && !(stale && count_reg == CW'(1));

    // value at the head once the new sample has been pushed
    assign front_val = nonempty ? $signed(head_ent_reg[SAMPLE_W-1:0]) : sample;

    // pointer and count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            if (last)
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            else
            begin
                tail_next  = ring_next(tail_reg);
                count_next = count_reg + 1'b1;
            end
        end
        else if (cmd.scan)
        begin
            if (expire)
            begin
                head_next = ring_next(head_reg);
            end
            if (pop)
            begin
                tail_next = ring_prev(tail_reg);
            end
            count_next = count_reg - CW'(expire) - CW'(pop);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // ring memory: push writes at the tail, head and last entry read back each cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push && !last)
        begin
            mem[tail_reg] <= {idx_low, sample};
        end
        head_ent_reg <= mem[head_next];
        tail_ent_reg <= mem[ring_prev(tail_next)];
    end

endmodule

FILE: src/swmm_dp.sv
// datapath: item and config registers, sample index, both deques, output register
`timescale 1ns / 1ps

module swmm_dp #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  swmm_pkg::swmm_cmd_t                   cmd,
    output swmm_pkg::swmm_status_t                status,
    input  logic                                  window_len_we,
    input  logic [swmm_pkg::WIN_LEN_W-1:0]        window_len,
    input  logic signed [swmm_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  last_sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [swmm_pkg::SAMPLE_W-1:0]  window_min,
    output logic signed [swmm_pkg::SAMPLE_W-1:0]  window_max
);
    import swmm_pkg::*;

    localparam int AW = $clog2(WINDOW_MAX) + 1;
    localparam logic [IDX_W-1:0] DEPTH = IDX_W'(WINDOW_MAX);

    logic [WIN_LEN_W-1:0]       window_len_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [AW-1:0]              k_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] min_reg;
    logic signed [SAMPLE_W-1:0] max_reg;

    logic [IDX_W-1:0]           wl_ext;
    logic [IDX_W-1:0]           k_eff;
    logic                       min_busy;
    logic                       max_busy;
    logic signed [SAMPLE_W-1:0] min_front;
    logic signed [SAMPLE_W-1:0] max_front;
    logic                       result_due;
    logic                       out_free;

    // window length clamped to 1..WINDOW_MAX
    assign wl_ext = IDX_W'(window_len_reg);
    always_comb
    begin
        if (wl_ext == '0)
        begin
            k_eff = IDX_W'(1);
        end
        else if (wl_ext > DEPTH)
        begin
            k_eff = DEPTH;
        end
        else
        begin
            k_eff = wl_ext;
        end
    end

    // a result is due once a full window has been seen
    assign result_due = (idx_reg >= (IDX_W'(k_reg) - 1'b1));
    assign out_free   = !out_valid_reg || out_ready;

    assign status.scan_busy  = min_busy || max_busy;
    assign status.result_due = result_due;
    assign status.out_free   = out_free;

    // next sample index, cleared at the end of a run
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.push)
        begin
            idx_next = last_reg ? '0 : idx_reg + 1'b1;
        end
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.push && result_due)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WIN_LEN_W'(1);
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (window_len_we)
            begin
                window_len_reg <= window_len;
            end
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
            last_reg   <= last_sample;
            k_reg      <= AW'(k_eff);
        end
        if (cmd.push && result_due)
        begin
            min_reg <= min_front;
            max_reg <= max_front;
        end
    end

    swmm_deque #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_min_deque (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .find_min  (1'b1),
        .last      (last_reg),
        .idx_low   (idx_reg[AW-1:0]),
        .win       (k_reg),
        .sample    (sample_reg),
        .busy      (min_busy),
        .front_val (min_front)
    );

    swmm_deque #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_max_deque (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .find_min  (1'b0),
        .last      (last_reg),
        .idx_low   (idx_reg[AW-1:0]),
        .win       (k_reg),
        .sample    (sample_reg),
        .busy      (max_busy),
        .front_val (max_front)
    );

    assign out_valid  = out_valid_reg;
    assign window_min = min_reg;
    assign window_max = max_reg;

endmodule

FILE: src/swmm_ctrl.sv
// controller: accept an item, scan both deques, push and hand off the result
`timescale 1ns / 1ps

module swmm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  swmm_pkg::swmm_status_t status,
    output swmm_pkg::swmm_cmd_t    cmd
);
    import swmm_pkg::*;

    swmm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // one head expiry and one tail pop per deque each cycle
                cmd.scan = 1'b1;
                if (!status.scan_busy)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                // hold while a due result cannot enter the output register
                if (!status.result_due || status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/sliding_window_min_max.sv
// Sliding-window minimum and maximum of a signed 32-bit sample stream. Each accepted
// item is loaded and then scanned, where a scan step drops one stale entry from the
// head and one dominated entry from the tail of each deque at once; the scan length
// is the largest number of head expiries or tail pops in either deque. The item is
// then pushed, which waits while a due result cannot enter the output register. The
// rate is set by the single-step scan over each deque's ring memory (one registered
// read per end per cycle). Results start once window_len items have been seen; an
// item flagged last_sample ends the run and clears the deques and the sample index.
// window_len is written by window_len_we; the user must write it only while the
// block is idle, which the block itself does not enforce. A value of 0 acts as 1 and
// values above WINDOW_MAX act as WINDOW_MAX. The output register lets a new item be
// accepted while a result waits.
`timescale 1ns / 1ps

module sliding_window_min_max #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 window_len_we,
    input  logic [swmm_pkg::WIN_LEN_W-1:0]       window_len,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [swmm_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 last_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] window_min,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] window_max
);
    import swmm_pkg::*;

    swmm_cmd_t    cmd;
    swmm_status_t status;

    // sequencing
    swmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // deques and result path
    swmm_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .window_len_we (window_len_we),
        .window_len    (window_len),
        .sample        (sample),
        .last_sample   (last_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .window_min    (window_min),
        .window_max    (window_max)
    );

endmodule

FILE: src/swmm_checker.sv
// port-level checks for the sliding window min/max block, bound to the top level
`timescale 1ns / 1ps
`include "sliding_window_min_max_assert.svh"

module swmm_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [swmm_pkg::SAMPLE_W-1:0] window_min,
    input logic signed [swmm_pkg::SAMPLE_W-1:0] window_max
);
    import swmm_pkg::*;

    // a stalled result holds its value
    `SWMM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(window_min) && $stable(window_max))

    // an accepted item keeps the input closed for the next cycle
    `SWMM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // the minimum never exceeds the maximum of the same window
    `SWMM_ASSERT_NOW(a_min_le_max, clk, rst_n, out_valid, window_min <= window_max)

    // a new result is produced only while the input is closed
    `SWMM_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind sliding_window_min_max swmm_checker u_swmm_checker (.*);

FILE: bench/sliding_window_min_max_tb.sv
// testbench for sliding_window_min_max: random stream against a deque predictor
`timescale 1ns / 1ps

module sliding_window_min_max_tb;

    import swmm_pkg::*;

    localparam int          WIN_CAP     = 1024;
    localparam int          SETTLE      = 1200;
    localparam int          HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [SAMPLE_W-1:0] val;
        logic                       fin;
    } stim_item_t;

    typedef struct {
        logic [IDX_W-1:0]           pos;
        logic signed [SAMPLE_W-1:0] val;
    } dq_entry_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
    } extrema_t;

    typedef enum int {
        MIX_WIDE,
        MIX_NARROW,
        MIX_RAMP,
        MIX_EDGE
    } mix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_we = 1'b0;
    logic [WIN_LEN_W-1:0]       cfg_len = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       last_in = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] min_out;
    logic signed [SAMPLE_W-1:0] max_out;

    // stimulus backlog and predicted results
    stim_item_t sample_backlog[$];
    extrema_t   pending_extrema[$];

    // predictor state
    dq_entry_t            lo_dq[$];
    dq_entry_t            hi_dq[$];
    logic [IDX_W-1:0]     next_pos = '0;
    logic [WIN_LEN_W-1:0] win_cfg = 11'd1;

    // generator state
    mix_t                       mix_mode = MIX_WIDE;
    logic signed [SAMPLE_W-1:0] ramp_acc = '0;
    logic signed [SAMPLE_W-1:0] ramp_step = 32'sd1;

    int unsigned tx_gap = 0;
    logic        tx_steady = 1'b0;
    int unsigned rx_gap = 0;
    logic        rx_steady = 1'b0;
    logic        hold_kick = 1'b0;
    int unsigned hold_left = 0;
    int unsigned fault_cnt = 0;
    int unsigned cycle_cnt = 0;

    sliding_window_min_max #(
        .WINDOW_MAX(WIN_CAP)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_len_we(cfg_we),
        .window_len   (cfg_len),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample_in),
        .last_sample  (last_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_min   (min_out),
        .window_max   (max_out)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // advance both monotonic deques by one sample, queue the result if the window is full
    function automatic void slide_window(logic signed [SAMPLE_W-1:0] v, logic fin);
        logic [IDX_W-1:0] span;
        if (win_cfg == '0)
            span = 1;
        else if (win_cfg > WIN_CAP)
            span = WIN_CAP;
        else
            span = {21'd0, win_cfg};

        // expire by age, then drop strictly beaten tail entries
        while (lo_dq.size() != 0 && (next_pos - lo_dq[0].pos) >= span)
            void'(lo_dq.pop_front());
        while (lo_dq.size() != 0 && lo_dq[$].val > v)
            void'(lo_dq.pop_back());
        if (lo_dq.size() >= WIN_CAP)
            void'(lo_dq.pop_front());
        lo_dq.push_back(dq_entry_t'{next_pos, v});

        while (hi_dq.size() != 0 && (next_pos - hi_dq[0].pos) >= span)
            void'(hi_dq.pop_front());
        while (hi_dq.size() != 0 && hi_dq[$].val < v)
            void'(hi_dq.pop_back());
        if (hi_dq.size() >= WIN_CAP)
            void'(hi_dq.pop_front());
        hi_dq.push_back(dq_entry_t'{next_pos, v});

        if (next_pos >= span - 1)
            pending_extrema.push_back(extrema_t'{lo_dq[0].val, hi_dq[0].val});

        next_pos = next_pos + 1;
        // end of run clears everything but the window length
        if (fin)
        begin
            lo_dq.delete();
            hi_dq.delete();
            next_pos = '0;
        end
    endfunction

    function automatic void log_fault(string what);
        fault_cnt++;
        if (fault_cnt <= 10)
            $display("%s", what);
    endfunction

    function automatic void add_item(logic signed [SAMPLE_W-1:0] v, logic fin);
        sample_backlog.push_back(stim_item_t'{v, fin});
    endfunction

    // sender: one item per handshake, random gap after each
    always @(posedge clk or negedge rst_n)
    begin : feed_side
        stim_item_t nxt;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            sample_in <= '0;
            last_in   <= 1'b0;
            tx_gap    <= 0;
            tx_steady <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                slide_window(sample_in, last_in);

            if (in_valid && !in_ready)
            begin
                // item still waiting, keep it on the bus
            end
            else if (tx_gap != 0)
            begin
                in_valid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end
            else if (sample_backlog.size() != 0)
            begin
                nxt       = sample_backlog.pop_front();
                sample_in <= nxt.val;
                last_in   <= nxt.fin;
                in_valid  <= 1'b1;
                tx_gap    <= tx_steady ? 0 : $urandom_range(0, 11);
                if ($urandom_range(0, 39) == 0)
                    tx_steady <= !tx_steady;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: compare each result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : take_side
        int unsigned pause_n;
        extrema_t    due;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap    <= 0;
            rx_steady <= 1'b0;
        end
        else
        begin
            pause_n = rx_gap;
            if (out_valid && out_ready)
            begin
                if (pending_extrema.size() == 0)
                    log_fault($sformatf("unexpected result: min %0d max %0d, none predicted",
                                        min_out, max_out));
                else
                begin
                    due = pending_extrema.pop_front();
                    if (min_out !== due.lo || max_out !== due.hi)
                        log_fault($sformatf(
                            "mismatch: expected min %0d max %0d, got min %0d max %0d",
                            due.lo, due.hi, min_out, max_out));
                end
                pause_n = rx_steady ? 0 : $urandom_range(0, 11);
                if ($urandom_range(0, 39) == 0)
                    rx_steady <= !rx_steady;
            end

            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                rx_gap    <= pause_n;
            end
            else if (pause_n != 0)
            begin
                out_ready <= 1'b0;
                rx_gap    <= pause_n - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                rx_gap    <= 0;
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // wait until every item is taken and every result is in, then let the block settle
    task automatic drain();
        do
            @(negedge clk);
        while (sample_backlog.size() != 0 || in_valid || pending_extrema.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_window(logic [WIN_LEN_W-1:0] len);
        drain();
        @(posedge clk);
        cfg_we  <= 1'b1;
        cfg_len <= len;
        win_cfg = len;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // random samples in changing flavors; last_odds 0 means no run end inside
    task automatic random_run(int count, int last_odds);
        logic signed [SAMPLE_W-1:0] v;
        logic                       fin;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                mix_mode  = mix_t'($urandom_range(0, 3));
                ramp_acc  = $urandom;
                ramp_step = $signed($urandom_range(0, 8)) - 4;
            end
            case (mix_mode)
                MIX_WIDE:   v = $urandom;
                MIX_NARROW: v = $signed($urandom_range(0, 6)) - 3;
                MIX_RAMP:
                begin
                    ramp_acc = ramp_acc + ramp_step;
                    v        = ramp_acc;
                end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       v = S_MIN;
                        1:       v = S_MAX;
                        2:       v = 0;
                        3:       v = -1;
                        4:       v = S_MIN + 1;
                        default: v = S_MAX - 1;
                    endcase
                end
            endcase
            fin = (last_odds != 0) && ($urandom_range(1, last_odds) == 1);
            add_item(v, fin);
        end
    endtask

    // stimulus sequence
    initial
    begin
        logic [WIN_LEN_W-1:0] w;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, equal values and run end with a window of three
        set_window(3);
        add_item(S_MIN, 1'b0);
        add_item(S_MAX, 1'b0);
        add_item(0, 1'b0);
        add_item(S_MAX, 1'b0);
        add_item(S_MAX, 1'b0);
        add_item(S_MIN, 1'b0);
        add_item(S_MIN, 1'b0);
        add_item(-1, 1'b0);
        add_item(1, 1'b0);
        add_item(5, 1'b0);
        add_item(5, 1'b0);
        add_item(5, 1'b1);

        // zero length behaves as one
        set_window(0);
        add_item(-7, 1'b0);
        add_item(3, 1'b0);
        add_item(3, 1'b1);

        set_window(1);
        add_item(S_MIN, 1'b0);
        add_item(1, 1'b1);

        // wide window: long rising ramp, then a low sample clears the min deque
        set_window(160);
        ramp_acc = -1000000;
        for (int i = 0; i < 180; i++)
        begin
            add_item(ramp_acc, 1'b0);
            ramp_acc = ramp_acc + 3;
        end
        add_item(-2000000000, 1'b0);
        ramp_acc = 2000000;
        for (int i = 0; i < 40; i++)
        begin
            add_item(ramp_acc, 1'b0);
            ramp_acc = ramp_acc - 7;
        end
        add_item(S_MAX, 1'b0);
        random_run(20, 0);

        // oversized lengths mid-run, then shrink mid-run
        set_window(2047);
        random_run(20, 0);
        set_window(1025);
        random_run(20, 0);
        set_window(5);
        random_run(30, 0);
        add_item($urandom, 1'b1);

        // grow mid-run
        set_window(4);
        random_run(20, 0);
        set_window(40);
        random_run(40, 0);
        add_item($urandom, 1'b1);

        set_window(1);
        random_run(30, 10);
        set_window(2);
        random_run(30, 12);

        // receiver stalls for a long stretch while items keep coming
        set_window(7);
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
        random_run(80, 30);

        set_window(16);
        random_run(50, 60);
        set_window(33);
        random_run(50, 110);
        set_window(0);
        random_run(30, 8);

        for (int p = 0; p < 4; p++)
        begin
            w = ($urandom_range(0, 3) != 0) ? WIN_LEN_W'($urandom_range(1, 64))
                                            : WIN_LEN_W'($urandom_range(0, 2047));
            set_window(w);
            random_run(30, 3 * int'(w) + 8);
        end

        drain();
        if (fault_cnt == 0 && pending_extrema.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
